// ----- sv/aging_fifo_queue_unit_macros.svh -----
// Assertion macros for the aging FIFO queue RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef AGING_FIFO_QUEUE_UNIT_MACROS_SVH
`define AGING_FIFO_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define AFQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AFQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/afq_pkg.sv -----
// Package for the aging FIFO queue: sizes, operation codes, register
// indexes and the beat structs passed between front and back. No dependencies.
`default_nettype none

package afq_pkg;

    localparam int DEPTH      = 16;
    localparam int DESC_W     = 32;
    localparam int TIME_W     = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = TIME_W;
    localparam int FQ_DEPTH   = 2;
    localparam int FQ_PTR_W   = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W   = $clog2(FQ_DEPTH + 1);

    localparam logic [CNT_W-1:0]  MAX_ENTRIES_RST = CNT_W'(DEPTH);
    localparam logic [TIME_W-1:0] MAX_DELAY_RST   = TIME_W'(1000000);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 1'b1;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_POLL  = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_CHECK = 1'b1
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] now_time;
        logic [DESC_W-1:0] descriptor;
    } t_item;

    typedef struct packed {
        logic              accepted;
        logic              found;
        logic [DESC_W-1:0] descriptor_out;
        logic [CNT_W-1:0]  expired_count;
        logic [CNT_W-1:0]  queue_size;
        logic              is_empty_flag;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/aging_fifo_queue_unit.sv -----
// Aging FIFO queue, top level. Input beats carry an operation (enqueue,
// dequeue, poll, flush), the current time and a descriptor; every input beat
// yields exactly one result beat, in order. Both channels use valid/stall.
// Configuration: i_cfg_we with i_cfg_index 0 (capacity) or 1 (lifetime);
// write only while the block is idle.
// A taken input beat waits in the front queue; the back end loads it in its
// idle state, then in its check state drops expired head entries (not on
// flush) and registers the result. Items are worked one at a time, over
// the stamp and descriptor RAM read port.
// A two-beat queue sits between front and back; o_stall rises when it fills.
// A stalled result holds in the output register while the next item is
// worked; the back end waits only when a new result is ready and the
// register is still held. Reset empties the queue, restores capacity 16 and
// lifetime 1000000; store contents are left as they are.
// Uses afq_pkg, afq_front, afq_back, afq_ram.
`default_nettype none

module aging_fifo_queue_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [afq_pkg::TIME_W-1:0]    i_now_time,
    input  wire logic [afq_pkg::DESC_W-1:0]    i_descriptor_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_accepted,
    output logic                               o_found,
    output logic      [afq_pkg::DESC_W-1:0]    o_descriptor_out,
    output logic      [afq_pkg::CNT_W-1:0]     o_expired_count,
    output logic      [afq_pkg::CNT_W-1:0]     o_queue_size,
    output logic                               o_is_empty_flag,
    input  wire logic                          i_cfg_we,
    input  wire logic [afq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [afq_pkg::CFG_W-1:0]     i_cfg_data
);

    import afq_pkg::*;

    t_item   w_item;
    logic    w_item_valid;
    logic    w_pop;
    t_result w_res;

    afq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_now_time      (i_now_time),
        .i_descriptor_in (i_descriptor_in),
        .o_item          (w_item),
        .o_item_valid    (w_item_valid),
        .i_pop           (w_pop)
    );

    afq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .o_res        (w_res),
        .o_res_valid  (o_valid),
        .i_res_stall  (i_stall)
    );

    assign o_accepted       = w_res.accepted;
    assign o_found          = w_res.found;
    assign o_descriptor_out = w_res.descriptor_out;
    assign o_expired_count  = w_res.expired_count;
    assign o_queue_size     = w_res.queue_size;
    assign o_is_empty_flag  = w_res.is_empty_flag;

endmodule

`default_nettype wire

// ----- sv/afq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module afq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/afq_front.sv -----
// Front end of the aging FIFO queue: takes input beats, decodes the
// operation and holds them in a short queue for the back end. Uses afq_pkg.
`default_nettype none

module afq_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [1:0]                i_operation,
    input  wire logic [afq_pkg::TIME_W-1:0] i_now_time,
    input  wire logic [afq_pkg::DESC_W-1:0] i_descriptor_in,
    output afq_pkg::t_item                 o_item,
    output logic                           o_item_valid,
    input  wire logic                      i_pop
);

    import afq_pkg::*;

    t_item               r_q [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FQ_CNT_W-1:0] r_fill, n_fill;
    logic                w_push;
    logic                w_pop;
    t_item               w_item;

    function automatic logic [FQ_PTR_W-1:0] fq_inc(input logic [FQ_PTR_W-1:0] p);
        return (p == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_stall      = (r_fill == FQ_CNT_W'(FQ_DEPTH));
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && o_item_valid;

    always_comb begin
        w_item.op         = t_op'(i_operation);
        w_item.now_time   = i_now_time;
        w_item.descriptor = i_descriptor_in;
        n_wr_ptr = w_push ? fq_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = w_pop ? fq_inc(r_rd_ptr) : r_rd_ptr;
        n_fill   = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/afq_back.sv -----
// Back end of the aging FIFO queue: expiry walk, enqueue, dequeue, flush,
// configuration registers and the result register. Uses afq_pkg, afq_ram.
`default_nettype none
`include "aging_fifo_queue_unit_macros.svh"

module afq_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [afq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [afq_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire afq_pkg::t_item                i_item,
    input  wire logic                          i_item_valid,
    output logic                               o_pop,
    output afq_pkg::t_result                   o_res,
    output logic                               o_res_valid,
    input  wire logic                          i_res_stall
);

    import afq_pkg::*;

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_exp, n_exp;
    logic [CNT_W-1:0]  r_max_entries, n_max_entries;
    logic [TIME_W-1:0] r_max_delay, n_max_delay;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic [TIME_W-1:0] w_rd_stamp;
    logic [DESC_W-1:0] w_rd_desc;
    logic [CNT_W-1:0]  w_cap;
    logic              w_is_exp;
    logic              w_expire;
    logic              w_finish;
    logic              w_we;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    afq_ram #(.WIDTH(DESC_W), .DEPTH(DEPTH)) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (r_item.descriptor),
        .i_raddr (n_head),
        .o_rdata (w_rd_desc)
    );

    afq_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (r_item.now_time),
        .i_raddr (n_head),
        .o_rdata (w_rd_stamp)
    );

    assign w_cap    = (r_max_entries > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_max_entries;
    assign w_is_exp = (r_item.now_time >= w_rd_stamp) &&
                      ((r_item.now_time - w_rd_stamp) >= r_max_delay);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        w_expire = 1'b0;
        w_finish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = i_item_valid;
            end
            ST_CHECK: begin
                w_expire = (r_item.op != OP_FLUSH) && (r_count != '0) && w_is_exp;
                w_finish = !w_expire && (!r_out_valid || !i_res_stall);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_item        = r_item;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_exp         = r_exp;
        n_max_entries = r_max_entries;
        n_max_delay   = r_max_delay;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        w_we          = 1'b0;

        if (o_pop) begin
            n_item = i_item;
            n_exp  = '0;
        end

        if (w_expire) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
            n_exp   = r_exp + 1'b1;
        end

        if (r_out_valid && !i_res_stall) begin
            n_out_valid = 1'b0;
        end

        if (w_finish) begin
            n_out.accepted       = 1'b0;
            n_out.found          = 1'b0;
            n_out.descriptor_out = '0;
            n_out.expired_count  = r_exp;
            case (r_item.op)
                OP_ENQ: begin
                    if (r_count < w_cap) begin
                        w_we           = 1'b1;
                        n_tail         = ptr_inc(r_tail);
                        n_count        = r_count + 1'b1;
                        n_out.accepted = 1'b1;
                    end
                end
                OP_DEQ: begin
                    if (r_count != '0) begin
                        n_head               = ptr_inc(r_head);
                        n_count              = r_count - 1'b1;
                        n_out.found          = 1'b1;
                        n_out.descriptor_out = w_rd_desc;
                    end
                end
                OP_POLL: ;
                OP_FLUSH: begin
                    n_count             = '0;
                    n_out.expired_count = '0;
                end
                default: ;
            endcase
            if (n_count == '0) begin
                n_head = '0;
                n_tail = '0;
            end
            n_out.queue_size    = n_count;
            n_out.is_empty_flag = (n_count == '0);
            n_out_valid         = 1'b1;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_ENTRIES: n_max_entries = i_cfg_data[CNT_W-1:0];
                CFG_MAX_DELAY:   n_max_delay   = i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_exp         <= '0;
            r_max_entries <= MAX_ENTRIES_RST;
            r_max_delay   <= MAX_DELAY_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_count       <= n_count;
            r_exp         <= n_exp;
            r_max_entries <= n_max_entries;
            r_max_delay   <= n_max_delay;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    `AFQ_ASSERT_IMP(a_empty_ptrs, r_state == ST_IDLE && r_count == '0, r_head == '0 && r_tail == '0, "empty queue with stray pointers")
    `AFQ_ASSERT_IMP(a_count_max, 1'b1, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `AFQ_ASSERT_IMP(a_acc_size, r_out_valid && r_out.accepted, r_out.queue_size != '0 && !r_out.is_empty_flag, "accepted beat reports empty queue")
    `AFQ_ASSERT_NXT(a_pop_start, o_pop, r_state == ST_CHECK && r_exp == '0, "item taken without fresh expiry walk")

endmodule

`default_nettype wire
